[hw/rtl/tea_block_cipher_unit_defines.svh]
// Assertion macros for the TEA block cipher unit
`ifndef TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// check while out of reset
`define TEA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check at every edge, reset included
`define TEA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/tea_pkg.sv]
package tea_pkg;

   localparam int MAX_ROUNDS = 64;
   localparam int NUM_CELLS  = 2 * MAX_ROUNDS;
   localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
   localparam int CSR_COUNT  = 6;
   localparam int CSR_ADDR_W = $clog2(CSR_COUNT * 4);

   localparam logic [31:0] TEA_DELTA       = 32'h9E37_79B9;
   localparam logic [6:0]  ROUND_RESET     = 7'd32;
   localparam logic        REQ_ENCRYPT     = 1'b0;
   localparam logic        REQ_DECRYPT     = 1'b1;

   typedef enum logic [2:0] {
      CSR_KEY0,
      CSR_KEY1,
      CSR_KEY2,
      CSR_KEY3,
      CSR_ROUNDS,
      CSR_SWAP
   } tea_csr_index_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } tea_key_type;

   typedef struct packed {
      tea_key_type key;
      logic [6:0]  round_count;
      logic        swap_bytes;
   } tea_cfg_type;

   typedef struct packed {
      logic               valid;
      logic               dec;
      logic               phase;
      logic [ROUND_W-1:0] left;
      logic [31:0]        sum;
      logic [31:0]        y;
      logic [31:0]        z;
   } tea_lane_type;

   function automatic logic [31:0] bswap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [31:0] order_word(input logic swap, input logic [31:0] v);
      return swap ? bswap32(v) : v;
   endfunction

endpackage

[hw/rtl/tea_if.sv]
interface tea_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] block_first;
   logic [31:0] block_second;

   modport source (output valid, req_type, block_first, block_second, input ready);
   modport sink (input valid, req_type, block_first, block_second, output ready);
endinterface

interface tea_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_first;
   logic [31:0] out_second;

   modport source (output valid, out_first, out_second, input ready);
   modport sink (input valid, out_first, out_second, output ready);
endinterface

[hw/rtl/tea_csr.sv]
module tea_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output tea_pkg::tea_cfg_type          cfg
);
   import tea_pkg::*;

   logic [31:0]       key_ff [4];
   logic [6:0]        rounds_ff;
   logic              swap_ff;
   logic              write_en;
   tea_csr_index_type index;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign index    = tea_csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
         rounds_ff <= ROUND_RESET;
         swap_ff   <= 1'b0;
      end else if (write_en) begin
         unique case (index)
            CSR_KEY0:   key_ff[0] <= pwdata;
            CSR_KEY1:   key_ff[1] <= pwdata;
            CSR_KEY2:   key_ff[2] <= pwdata;
            CSR_KEY3:   key_ff[3] <= pwdata;
            CSR_ROUNDS: rounds_ff <= pwdata[6:0];
            CSR_SWAP:   swap_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_KEY0:   prdata = key_ff[0];
         CSR_KEY1:   prdata = key_ff[1];
         CSR_KEY2:   prdata = key_ff[2];
         CSR_KEY3:   prdata = key_ff[3];
         CSR_ROUNDS: prdata = {25'd0, rounds_ff};
         CSR_SWAP:   prdata = {31'd0, swap_ff};
         default:    prdata = '0;
      endcase
   end

   assign cfg.key.a       = order_word(swap_ff, key_ff[0]);
   assign cfg.key.b       = order_word(swap_ff, key_ff[1]);
   assign cfg.key.c       = order_word(swap_ff, key_ff[2]);
   assign cfg.key.d       = order_word(swap_ff, key_ff[3]);
   assign cfg.round_count = rounds_ff;
   assign cfg.swap_bytes  = swap_ff;

endmodule

[hw/rtl/tea_entry.sv]
module tea_entry (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  req_valid,
   input  logic                  req_type,
   input  logic [31:0]           block_first,
   input  logic [31:0]           block_second,
   input  tea_pkg::tea_cfg_type  cfg,
   output tea_pkg::tea_lane_type lane_out
);
   import tea_pkg::*;

   tea_lane_type       lane_ff;
   tea_lane_type       lane_in;
   logic [31:0]        count_wide;
   logic [ROUND_W-1:0] rounds;

   always_comb begin
      count_wide = 32'(cfg.round_count);
      if (count_wide > 32'(MAX_ROUNDS)) begin
         rounds = ROUND_W'(MAX_ROUNDS);
      end else begin
         rounds = ROUND_W'(count_wide);
      end
      lane_in.valid = req_valid;
      lane_in.dec   = req_type;
      lane_in.phase = 1'b0;
      lane_in.left  = rounds;
      lane_in.y     = order_word(cfg.swap_bytes, block_first);
      lane_in.z     = order_word(cfg.swap_bytes, block_second);
      if (req_type == REQ_DECRYPT) begin
         lane_in.sum = 32'(TEA_DELTA * 32'(rounds));
      end else begin
         lane_in.sum = TEA_DELTA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

[hw/rtl/tea_cell.sv]
module tea_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  tea_pkg::tea_key_type  key,
   input  tea_pkg::tea_lane_type lane_i,
   output tea_pkg::tea_lane_type lane_o
);
   import tea_pkg::*;

   tea_lane_type lane_ff;
   tea_lane_type lane_in;
   logic         sel;
   logic [31:0]  v;
   logic [31:0]  ka;
   logic [31:0]  kb;
   logic [31:0]  mix;
   logic [31:0]  target;
   logic [31:0]  result;

   always_comb begin
      sel    = lane_i.phase ^ lane_i.dec;
      v      = sel ? lane_i.y : lane_i.z;
      ka     = sel ? key.c : key.a;
      kb     = sel ? key.d : key.b;
      mix    = ((v << 4) + ka) ^ (v + lane_i.sum) ^ ((v >> 5) + kb);
      target = sel ? lane_i.z : lane_i.y;
      result = (lane_i.dec == REQ_DECRYPT) ? target - mix : target + mix;

      lane_in       = lane_i;
      lane_in.phase = ~lane_i.phase;
      if (lane_i.left != '0) begin
         if (sel) begin
            lane_in.z = result;
         end else begin
            lane_in.y = result;
         end
         if (lane_i.phase) begin
            lane_in.left = lane_i.left - ROUND_W'(1);
            lane_in.sum  = (lane_i.dec == REQ_DECRYPT) ? lane_i.sum - TEA_DELTA
                                                       : lane_i.sum + TEA_DELTA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

[hw/rtl/tea_block_cipher_unit.sv]
// TEA block cipher unit: encrypts or decrypts one 64-bit block per cycle under the
// 128-bit key and round count held in the APB registers. Each block walks a chain of
// 2*MAX_ROUNDS half-round cells behind one entry stage and ahead of one output register,
// so every block passes the entry stage, all cells and the output register in turn,
// whatever round count is set; cells past the last round pass the block on.
// The chain holds as a whole while a finished result waits to be taken, so requests
// are taken whenever the output register is empty or is being emptied. Registers may
// be written only while no block is in flight.
`include "tea_block_cipher_unit_defines.svh"

module tea_block_cipher_unit (
   input  logic                           clock,
   input  logic                           reset,
   tea_req_if.sink                        req_chan,
   tea_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import tea_pkg::*;

   tea_cfg_type  cfg;
   tea_lane_type lane [NUM_CELLS+1];
   logic         advance;
   logic         rsp_valid_ff;
   logic [31:0]  first_ff;
   logic [31:0]  second_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   tea_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tea_entry u_entry (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req_valid    (req_chan.valid),
      .req_type     (req_chan.req_type),
      .block_first  (req_chan.block_first),
      .block_second (req_chan.block_second),
      .cfg          (cfg),
      .lane_out     (lane[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      tea_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .key     (cfg.key),
         .lane_i  (lane[k]),
         .lane_o  (lane[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= lane[NUM_CELLS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         first_ff  <= order_word(cfg.swap_bytes, lane[NUM_CELLS].y);
         second_ff <= order_word(cfg.swap_bytes, lane[NUM_CELLS].z);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_first  = first_ff;
   assign rsp_chan.out_second = second_ff;

   `TEA_ASSERT(a_stall_blocks_req, (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready, "request taken while result stalled")
   `TEA_ASSERT(a_rounds_saturated, lane[0].valid |-> (32'(lane[0].left) <= 32'(MAX_ROUNDS)), "round count above maximum")
   `TEA_ASSERT(a_rounds_done, lane[NUM_CELLS].valid |-> (lane[NUM_CELLS].left == '0), "block left chain with rounds pending")
   `TEA_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_valid_ff, "result valid after reset")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import tea_pkg::*;

   localparam logic [31:0] GOLDEN_DELTA   = 32'h9E37_79B9;
   localparam int          TEA_ROUND_CAP  = 64;
   localparam int          PIPE_LATENCY   = 130;
   localparam int          FAULTS_SHOWN   = 10;
   localparam int          RANDOM_PHASES  = 7;
   localparam int          PHASE_BLOCKS   = 107;
   localparam logic [2:0]  CSR_SPARE_LO   = 3'd6;
   localparam logic [2:0]  CSR_SPARE_HI   = 3'd7;

   typedef struct packed {
      logic [31:0] first;
      logic [31:0] second;
   } tea_block_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   tea_req_if req_if ();
   tea_rsp_if rsp_if ();

   tea_block_cipher_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   logic [31:0] key_words [4];
   logic [6:0]  rounds_cfg;
   logic        swap_cfg;

   tea_block_type expected_blocks [$];
   int         faults;
   int         blocks_checked;
   int         encrypt_sent;
   int         decrypt_sent;
   int         csr_writes;
   bit         quiet_tail;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [31:0] byte_flip(input logic [31:0] v);
      return {<<8{v}};
   endfunction

   function automatic logic [31:0] feistel_mix(input logic [31:0] v, input logic [31:0] sum,
                                              input logic [31:0] ka, input logic [31:0] kb);
      return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
   endfunction

   function automatic tea_block_type tea_predict(input logic dec, input logic [31:0] first,
                                                 input logic [31:0] second);
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] k [4];
      logic [31:0] sum;
      logic [31:0] n;
      tea_block_type res;
      y = swap_cfg ? byte_flip(first) : first;
      z = swap_cfg ? byte_flip(second) : second;
      for (int i = 0; i < 4; i++)
         k[i] = swap_cfg ? byte_flip(key_words[i]) : key_words[i];
      n = (rounds_cfg > TEA_ROUND_CAP) ? TEA_ROUND_CAP : rounds_cfg;
      if (dec == REQ_ENCRYPT) begin
         sum = '0;
         for (int i = 0; i < n; i++) begin
            sum = sum + GOLDEN_DELTA;
            y = y + feistel_mix(z, sum, k[0], k[1]);
            z = z + feistel_mix(y, sum, k[2], k[3]);
         end
      end else begin
         sum = GOLDEN_DELTA * n;
         for (int i = 0; i < n; i++) begin
            z = z - feistel_mix(y, sum, k[2], k[3]);
            y = y - feistel_mix(z, sum, k[0], k[1]);
            sum = sum - GOLDEN_DELTA;
         end
      end
      res.first = swap_cfg ? byte_flip(y) : y;
      res.second = swap_cfg ? byte_flip(z) : z;
      return res;
   endfunction

   task automatic note_fault(input string what, input logic [31:0] want, input logic [31:0] got);
      faults++;
      if (faults <= FAULTS_SHOWN)
         $display("MISMATCH %s: expected %h, got %h at %0t ns", what, want, got, $time);
   endtask

   // check each result transfer against the oldest outstanding block
   always @(posedge clock) begin
      tea_block_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_blocks.size() == 0) begin
            note_fault("unexpected result out_first", '0, rsp_if.out_first);
         end else begin
            want = expected_blocks.pop_front();
            blocks_checked++;
            if (want.first !== rsp_if.out_first)
               note_fault("out_first", want.first, rsp_if.out_first);
            if (want.second !== rsp_if.out_second)
               note_fault("out_second", want.second, rsp_if.out_second);
         end
      end
   end

   // result side: stall in random bursts, none in the tail
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({index, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (tea_csr_index_type'(index))
         CSR_KEY0: key_words[0] = value;
         CSR_KEY1: key_words[1] = value;
         CSR_KEY2: key_words[2] = value;
         CSR_KEY3: key_words[3] = value;
         CSR_ROUNDS: rounds_cfg = value[6:0];
         CSR_SWAP: swap_cfg = value[0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_config(input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3,
                             input logic [31:0] rounds, input logic [31:0] swap);
      csr_write(CSR_KEY0, k0);
      csr_write(CSR_KEY1, k1);
      csr_write(CSR_KEY2, k2);
      csr_write(CSR_KEY3, k3);
      csr_write(CSR_ROUNDS, rounds);
      csr_write(CSR_SWAP, swap);
   endtask

   task automatic send_block(input logic dec, input logic [31:0] first, input logic [31:0] second);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= dec;
      req_if.block_first <= first;
      req_if.block_second <= second;
      do @(posedge clock); while (!req_if.ready);
      expected_blocks.push_back(tea_predict(dec, first, second));
      if (dec == REQ_ENCRYPT)
         encrypt_sent++;
      else
         decrypt_sent++;
   endtask

   // hold off until every outstanding block has come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_block(REQ_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(REQ_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(REQ_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(REQ_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain_results();
   endtask

   task automatic test_key_and_block_extremes();
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32, 0);
      send_block(REQ_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_block(REQ_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_block(REQ_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      send_block(REQ_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
      drain_results();
      set_config(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, 32, 1);
      send_block(REQ_ENCRYPT, 32'h0011_2233, 32'h4455_6677);
      send_block(REQ_DECRYPT, 32'h8899_AABB, 32'hCCDD_EEFF);
      drain_results();
   endtask

   task automatic test_round_extremes();
      logic [31:0] round_writes [5] = '{32'h0, 32'h1, 32'h10, 32'h40, 32'hFFFF_FFC5};
      for (int i = 0; i < 5; i++) begin
         csr_write(CSR_ROUNDS, round_writes[i]);
         csr_write(CSR_SWAP, (i % 2 == 0) ? 32'h0000_0001 : 32'hFFFF_FFFE);
         send_block(REQ_ENCRYPT, $urandom, $urandom);
         send_block(REQ_DECRYPT, $urandom, $urandom);
         drain_results();
      end
   endtask

   task automatic test_register_corners();
      csr_write(CSR_ROUNDS, 32'hFFFF_FFFF);
      csr_write(CSR_SPARE_LO, $urandom);
      csr_write(CSR_SPARE_HI, $urandom);
      send_block(REQ_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
      send_block(REQ_DECRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
      drain_results();
   endtask

   task automatic random_config();
      logic [31:0] k [4];
      logic [6:0]  rounds;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 5))
            0: k[i] = 32'h0000_0000;
            1: k[i] = 32'hFFFF_FFFF;
            default: k[i] = $urandom;
         endcase
      end
      case ($urandom_range(0, 7))
         0: rounds = 7'd0;
         1: rounds = 7'd1;
         2: rounds = 7'd64;
         3: rounds = 7'd127;
         4: rounds = 7'($urandom_range(65, 126));
         default: rounds = 7'($urandom_range(2, 63));
      endcase
      set_config(k[0], k[1], k[2], k[3],
                 ($urandom & 32'hFFFF_FF80) | 32'(rounds), $urandom);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         random_config();
         if (phase == RANDOM_PHASES - 1)
            quiet_tail = 1'b1;
         for (int i = 0; i < PHASE_BLOCKS; i++) begin
            send_block(1'($urandom_range(0, 1)), $urandom, $urandom);
            if (phase == 3 && i == PHASE_BLOCKS / 2)
               drain_results();
         end
      end
      drain_results();
   endtask

   initial begin
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_if.valid <= 1'b0;
      req_if.req_type <= REQ_ENCRYPT;
      req_if.block_first <= '0;
      req_if.block_second <= '0;
      key_words = '{default: '0};
      rounds_cfg = ROUND_RESET;
      swap_cfg = 1'b0;
      faults = 0;
      blocks_checked = 0;
      encrypt_sent = 0;
      decrypt_sent = 0;
      csr_writes = 0;
      quiet_tail = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_key_and_block_extremes();
      test_round_extremes();
      test_register_corners();
      test_random_traffic();

      repeat (PIPE_LATENCY + 20) @(posedge clock);
      if (expected_blocks.size() != 0)
         note_fault("blocks never returned", 32'(expected_blocks.size()), '0);

      $display("Checked %0d blocks (%0d encrypt, %0d decrypt) over %0d register writes,",
               blocks_checked, encrypt_sent, decrypt_sent, csr_writes);
      $display("round counts 0 to 127 with and without byte swapping; %0d faults.", faults);
      if (faults == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tea_pkg.sv
hw/rtl/tea_if.sv
hw/rtl/tea_csr.sv
hw/rtl/tea_entry.sv
hw/rtl/tea_cell.sv
hw/rtl/tea_block_cipher_unit.sv
sim/tb.sv
